/* hdl/fifo_and_max_priority_server_core_defines.svh */
// Assertion macros for the RTL core.
`ifndef FIFO_AND_MAX_PRIORITY_SERVER_CORE_DEFINES_SVH
`define FIFO_AND_MAX_PRIORITY_SERVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FMPS_ASSERT(name, clk_sig, rst_sig, prop, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);
`define FMPS_ASSERT_NEVER(name, clk_sig, rst_sig, expr, msg) \
    `FMPS_ASSERT(name, clk_sig, rst_sig, !(expr), msg)
`else
`define FMPS_ASSERT(name, clk_sig, rst_sig, prop, msg)
`define FMPS_ASSERT_NEVER(name, clk_sig, rst_sig, expr, msg)
`endif

`endif

/* hdl/fmps_pkg.sv */
package fmps_pkg;

    localparam int VALUE_W    = 32;
    localparam int ID_W       = 20;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_INSERT        = 2'd0;
    localparam cmd_t CMD_SERVE_OLDEST  = 2'd1;
    localparam cmd_t CMD_SERVE_LARGEST = 2'd2;

    localparam status_t ST_INSERTED = 2'd0;
    localparam status_t ST_SERVED   = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ID_W-1:0]    id;
        logic               served;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_DATA,
        S_SCAN,
        S_SCAN_END,
        S_REL_RD,
        S_REL_CHK,
        S_RESULT
    } state_t;

endpackage

/* hdl/fifo_and_max_priority_server_core.sv */
// Priority server: a ring of DEPTH entries served oldest first or largest first.
// Input channel s_*: s_tuser carries the command (insert, serve oldest, serve
// largest; code 3 acts as serve largest), s_tdata carries the value to insert.
// Output channel m_*: one transaction per command, m_tdata carries the id that
// was assigned or served, m_tuser carries the status (inserted, served, empty,
// full). Commands are handled one at a time; s_tready is high only when the
// sequencer is idle, which it is again the cycle after a result is loaded.
// An insert, and a serve on an empty ring, go straight to the result state.
// Serve oldest reads the head entry, advances the head, then checks the slots
// after it and skips those already served until the ring is empty or an
// unserved slot is found. Serve largest scans every occupied slot, reading
// the entry memory once per cycle, then marks the chosen entry served or, when
// it is the head, retires the head and skips served slots in the same way.
// The single read port of the entry memory sets the cost of these steps.
// Reset empties the ring and sets the next id to one; the entry memory is not
// cleared since only slots written by an insert are ever read.
// A result waits in the output register while m_tready is low; the next
// command is accepted and worked on, and its result is held until the output
// register frees up.
`include "fifo_and_max_priority_server_core_defines.svh"

module fifo_and_max_priority_server_core #(
    parameter int DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fmps_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] item_value
    input  logic [fmps_pkg::CMD_W-1:0]        s_tuser,   // [1:0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fmps_pkg::OUT_DATA_W-1:0]   m_tdata,   // [19:0] served_id, zero pad
    output logic [fmps_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    fmps_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]           head_reg, head_next;
    logic [SLOT_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [fmps_pkg::ID_W-1:0]   next_id_reg, next_id_next;
    logic [SLOT_W-1:0]           scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]            scan_left_reg, scan_left_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]           rd_slot_reg, rd_slot_next;
    logic                        first_reg, first_next;
    logic [SLOT_W-1:0]           best_slot_reg, best_slot_next;
    logic [fmps_pkg::VALUE_W-1:0] best_value_reg, best_value_next;
    logic [fmps_pkg::ID_W-1:0]   best_id_reg, best_id_next;
    logic [fmps_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    fmps_pkg::status_t           res_status_reg, res_status_next;

    logic                        m_valid_reg;
    logic [fmps_pkg::ID_W-1:0]   m_id_reg;
    fmps_pkg::status_t           m_status_reg;

    logic                        mem_we;
    logic [SLOT_W-1:0]           mem_waddr;
    fmps_pkg::entry_t            mem_wdata;
    logic [SLOT_W-1:0]           mem_raddr;
    fmps_pkg::entry_t            rd_data;

    logic                        s_accept;
    logic                        out_free;
    fmps_pkg::cmd_t              cmd_in;
    logic                        is_full;
    logic                        is_empty;

    assign s_tready = (state_reg == fmps_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cmd_in   = s_tuser;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    fmps_ram #(
        .WIDTH (fmps_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmps_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    if (cmd_in == fmps_pkg::CMD_INSERT || is_empty)
                    begin
                        state_next = fmps_pkg::S_RESULT;
                    end
                    else if (cmd_in == fmps_pkg::CMD_SERVE_OLDEST)
                    begin
                        state_next = fmps_pkg::S_HEAD_DATA;
                    end
                    else
                    begin
                        state_next = fmps_pkg::S_SCAN;
                    end
                end
            end
            fmps_pkg::S_HEAD_DATA:
            begin
                state_next = fmps_pkg::S_REL_RD;
            end
            fmps_pkg::S_SCAN:
            begin
                if (scan_left_reg == '0)
                begin
                    state_next = fmps_pkg::S_SCAN_END;
                end
            end
            fmps_pkg::S_SCAN_END:
            begin
                state_next = (best_slot_reg == head_reg) ? fmps_pkg::S_REL_RD
                                                         : fmps_pkg::S_RESULT;
            end
            fmps_pkg::S_REL_RD:
            begin
                state_next = is_empty ? fmps_pkg::S_RESULT : fmps_pkg::S_REL_CHK;
            end
            fmps_pkg::S_REL_CHK:
            begin
                state_next = rd_data.served ? fmps_pkg::S_REL_RD : fmps_pkg::S_RESULT;
            end
            fmps_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = fmps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fmps_pkg::S_IDLE;
            end
        endcase
    end

    // Memory port controls.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = '{value: s_tdata, id: next_id_reg, served: 1'b0};
        mem_raddr = head_reg;
        case (state_reg)
            fmps_pkg::S_IDLE:
            begin
                mem_we = s_accept && (cmd_in == fmps_pkg::CMD_INSERT) && !is_full;
            end
            fmps_pkg::S_SCAN:
            begin
                mem_raddr = scan_addr_reg;
            end
            fmps_pkg::S_SCAN_END:
            begin
                // An entry served out of order keeps its slot until the head passes it.
                mem_we    = (best_slot_reg != head_reg);
                mem_waddr = best_slot_reg;
                mem_wdata = '{value: best_value_reg, id: best_id_reg, served: 1'b1};
            end
            default:
            begin
                mem_raddr = head_reg;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        rd_pend_next    = rd_pend_reg;
        rd_slot_next    = rd_slot_reg;
        first_next      = first_reg;
        best_slot_next  = best_slot_reg;
        best_value_next = best_value_reg;
        best_id_next    = best_id_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            fmps_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    res_id_next     = '0;
                    res_status_next = fmps_pkg::ST_SERVED;
                    if (cmd_in == fmps_pkg::CMD_INSERT)
                    begin
                        if (is_full)
                        begin
                            res_status_next = fmps_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_id_next     = next_id_reg;
                            res_status_next = fmps_pkg::ST_INSERTED;
                            tail_next       = slot_after(tail_reg);
                            count_next      = count_reg + 1'b1;
                            next_id_next    = next_id_reg + 1'b1;
                        end
                    end
                    else if (is_empty)
                    begin
                        res_status_next = fmps_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        scan_addr_next = head_reg;
                        scan_left_next = count_reg;
                        rd_pend_next   = 1'b0;
                        first_next     = 1'b1;
                    end
                end
            end
            fmps_pkg::S_HEAD_DATA:
            begin
                res_id_next = rd_data.id;
                head_next   = slot_after(head_reg);
                count_next  = count_reg - 1'b1;
            end
            fmps_pkg::S_SCAN:
            begin
                if (scan_left_reg != '0)
                begin
                    scan_addr_next = slot_after(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_slot_next   = scan_addr_reg;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                // Strict compare keeps the earliest entry on equal values.
                if (rd_pend_reg &&
                    (first_reg || (!rd_data.served && rd_data.value > best_value_reg)))
                begin
                    best_slot_next  = rd_slot_reg;
                    best_value_next = rd_data.value;
                    best_id_next    = rd_data.id;
                    first_next      = 1'b0;
                end
            end
            fmps_pkg::S_SCAN_END:
            begin
                res_id_next = best_id_reg;
                if (best_slot_reg == head_reg)
                begin
                    head_next  = slot_after(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            fmps_pkg::S_REL_CHK:
            begin
                if (rd_data.served)
                begin
                    head_next  = slot_after(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fmps_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            next_id_reg <= fmps_pkg::ID_W'(1);
            scan_left_reg <= '0;
            rd_pend_reg <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            scan_left_reg <= scan_left_next;
            rd_pend_reg   <= rd_pend_next;
            first_reg     <= first_next;
            if (state_reg == fmps_pkg::S_RESULT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg  <= scan_addr_next;
        rd_slot_reg    <= rd_slot_next;
        best_slot_reg  <= best_slot_next;
        best_value_reg <= best_value_next;
        best_id_reg    <= best_id_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        if (state_reg == fmps_pkg::S_RESULT && out_free)
        begin
            m_id_reg     <= res_id_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = fmps_pkg::OUT_DATA_W'(m_id_reg);
    assign m_tuser  = m_status_reg;

    // Where the tail must sit given the head and the occupancy.
    logic [CNT_W:0] ring_sum;
    logic [CNT_W:0] ring_tail;
    assign ring_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign ring_tail = (ring_sum >= (CNT_W + 1)'(DEPTH)) ?
                       ring_sum - (CNT_W + 1)'(DEPTH) : ring_sum;

    `FMPS_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_CNT, "occupancy above depth")
    `FMPS_ASSERT(a_ring_tail, clk, rst_n, tail_reg == SLOT_W'(ring_tail), "tail out of step")
    `FMPS_ASSERT(a_insert_grows, clk, rst_n,
        (s_accept && cmd_in == fmps_pkg::CMD_INSERT && !is_full) |=>
        (count_reg == $past(count_reg) + 1'b1), "insert lost")
    `FMPS_ASSERT_NEVER(a_no_write_in_scan, clk, rst_n,
        (state_reg == fmps_pkg::S_SCAN) && mem_we, "write during scan")
    `FMPS_ASSERT(a_head_unserved, clk, rst_n,
        (state_reg == fmps_pkg::S_SCAN && rd_pend_reg && first_reg) |-> !rd_data.served,
        "head entry marked served")

endmodule

/* hdl/fmps_ram.sv */
module fmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* bench/tb_fifo_and_max_priority_server_core.sv */
`timescale 1ns / 100ps

module tb_fifo_and_max_priority_server_core;

    localparam int RING_DEPTH   = 256;
    localparam int PHASE_ITEMS  = 435;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;

    // The unused command code behaves as serve largest.
    localparam fmps_pkg::cmd_t CMD_SERVE_LARGEST_ALT = 2'd3;

    typedef struct packed {
        fmps_pkg::cmd_t               cmd;
        logic [fmps_pkg::VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [fmps_pkg::ID_W-1:0] id;
        fmps_pkg::status_t         status;
    } reply_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fmps_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [fmps_pkg::CMD_W-1:0]      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fmps_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [fmps_pkg::STATUS_W-1:0]   m_tuser;

    fifo_and_max_priority_server_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 clk = ~clk;

    // Shadow copy of the ring, starting in its reset state.
    logic [fmps_pkg::VALUE_W-1:0] ring_value  [RING_DEPTH];
    logic [fmps_pkg::ID_W-1:0]    ring_id     [RING_DEPTH];
    bit                           ring_served [RING_DEPTH];
    int unsigned                  ring_head = 0;
    int unsigned                  ring_tail = 0;
    int unsigned                  ring_used = 0;
    logic [fmps_pkg::ID_W-1:0]    id_next   = 1;

    request_t    cmd_backlog[$];
    reply_t      replies_due[$];
    request_t    staged_req;
    request_t    taken_req;
    reply_t      due_reply;
    int unsigned cmds_queued    = 0;
    int unsigned cmds_taken     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned status_seen [4];

    function automatic int unsigned next_slot(int unsigned slot);
        return (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
    endfunction

    // Free the head slot, then every served slot that follows it.
    function automatic void retire_head();
        ring_served[ring_head] = 1'b0;
        ring_head = next_slot(ring_head);
        ring_used--;
        while (ring_used != 0 && ring_served[ring_head])
        begin
            ring_served[ring_head] = 1'b0;
            ring_head = next_slot(ring_head);
            ring_used--;
        end
    endfunction

    function automatic reply_t ring_reply(request_t req);
        reply_t      rep;
        int unsigned best;
        int unsigned slot;
        int unsigned n;
        rep.id = '0;
        if (req.cmd == fmps_pkg::CMD_INSERT)
        begin
            if (ring_used >= RING_DEPTH)
            begin
                rep.status = fmps_pkg::ST_FULL;
            end
            else
            begin
                ring_value[ring_tail]  = req.value;
                ring_id[ring_tail]     = id_next;
                ring_served[ring_tail] = 1'b0;
                rep.id     = id_next;
                rep.status = fmps_pkg::ST_INSERTED;
                ring_tail  = next_slot(ring_tail);
                ring_used++;
                id_next++;
            end
        end
        else if (ring_used == 0)
        begin
            rep.status = fmps_pkg::ST_EMPTY;
        end
        else if (req.cmd == fmps_pkg::CMD_SERVE_OLDEST)
        begin
            rep.id     = ring_id[ring_head];
            rep.status = fmps_pkg::ST_SERVED;
            retire_head();
        end
        else
        begin
            // Strictly greater wins, so the earliest of equal values is kept.
            best = ring_head;
            slot = ring_head;
            for (n = 0; n < ring_used; n++)
            begin
                if (!ring_served[slot] && ring_value[slot] > ring_value[best])
                    best = slot;
                slot = next_slot(slot);
            end
            rep.id     = ring_id[best];
            rep.status = fmps_pkg::ST_SERVED;
            if (best == ring_head)
                retire_head();
            else
                ring_served[best] = 1'b1;
        end
        return rep;
    endfunction

    function automatic logic [fmps_pkg::VALUE_W-1:0] pick_value();
        logic [fmps_pkg::VALUE_W-1:0] v;
        int unsigned                  roll;
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            v = $urandom_range(7);
        end
        else if (roll < 40)
        begin
            case ($urandom_range(3))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h8000_0000;
                default: v = 32'h7FFF_FFFF;
            endcase
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic fmps_pkg::cmd_t pick_serve();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return fmps_pkg::CMD_SERVE_OLDEST;
        else if (roll < 90)
            return fmps_pkg::CMD_SERVE_LARGEST;
        else
            return CMD_SERVE_LARGEST_ALT;
    endfunction

    task automatic queue_cmd(fmps_pkg::cmd_t cmd, logic [fmps_pkg::VALUE_W-1:0] value);
        request_t req;
        req.cmd   = cmd;
        req.value = value;
        cmd_backlog = {cmd_backlog, req};
        cmds_queued++;
    endtask

    task automatic queue_inserts(int unsigned count);
        repeat (count) queue_cmd(fmps_pkg::CMD_INSERT, pick_value());
    endtask

    task automatic queue_serves(int unsigned count);
        repeat (count) queue_cmd(pick_serve(), $urandom);
    endtask

    task automatic queue_mixed(int unsigned count, int unsigned insert_pct);
        repeat (count)
        begin
            if ($urandom_range(99) < insert_pct)
                queue_cmd(fmps_pkg::CMD_INSERT, pick_value());
            else
                queue_cmd(pick_serve(), $urandom);
        end
    endtask

    task automatic wait_for_replies();
        while (!(cmds_taken == cmds_queued && replies_due.size() == 0))
            @(negedge clk);
    endtask

    // Driver: the prediction is made for every command transaction in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                taken_req.cmd   = s_tuser;
                taken_req.value = s_tdata;
                replies_due = {replies_due, ring_reply(taken_req)};
                cmds_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    staged_req = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= staged_req.cmd;
                    s_tdata  <= staged_req.value;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result transaction is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual id %h status %0d",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end
                else
                begin
                    due_reply = replies_due.pop_front();
                    if (m_tdata !== {{(fmps_pkg::OUT_DATA_W-fmps_pkg::ID_W){1'b0}},
                                     due_reply.id})
                    begin
                        $display("%0t: served_id mismatch, expected %h actual %h",
                                 $time, due_reply.id, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== due_reply.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, due_reply.status, m_tuser);
                        error_count++;
                    end
                    status_seen[due_reply.status]++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("fifo_and_max_priority_server_core regression: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned roll;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Serves on an empty table, including the unused command code.
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        queue_cmd(CMD_SERVE_LARGEST_ALT, $urandom);
        // Equal maxima: the earlier one goes first, and served slots behind the
        // head are skipped once the head is taken.
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h0000_0000);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h0000_0007);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h0000_0007);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        queue_cmd(CMD_SERVE_LARGEST_ALT, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        // The comparison is unsigned.
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h8000_0000);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'h5555_5555);
        queue_cmd(fmps_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_OLDEST, $urandom);
        queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
        wait_for_replies();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 54; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct = 9;  recv_stall_pct = 9;
                end
            endcase
            phase_start = cmds_queued;
            if (phase == 1 || phase == 3)
            begin
                // Overfill, punch holes behind the head so the table stays full,
                // then drain part of it.
                queue_inserts(RING_DEPTH + 6);
                repeat (6) queue_cmd(fmps_pkg::CMD_SERVE_LARGEST, $urandom);
                queue_inserts(4);
                queue_serves(60);
            end
            while (cmds_queued - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 50)
                    queue_mixed($urandom_range(40, 10), $urandom_range(70, 30));
                else if (roll < 75)
                    queue_inserts($urandom_range(30, 5));
                else
                    queue_serves($urandom_range(30, 5));
            end
            wait_for_replies();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d commands under four idle and stall mixes, table filled twice.",
                 cmds_taken);
        $display("Results: %0d inserted, %0d served, %0d on empty table, %0d on full table.",
                 status_seen[fmps_pkg::ST_INSERTED], status_seen[fmps_pkg::ST_SERVED],
                 status_seen[fmps_pkg::ST_EMPTY], status_seen[fmps_pkg::ST_FULL]);
        if (error_count == 0)
            $display("fifo_and_max_priority_server_core regression: pass");
        else
            $display("fifo_and_max_priority_server_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/fmps_pkg.sv
hdl/fmps_ram.sv
hdl/fifo_and_max_priority_server_core.sv
bench/tb_fifo_and_max_priority_server_core.sv
